@@ sv/cfa_pkg.sv @@
// ----------------------------------------------------------------------------
// cfa_pkg: shared types and constants
// Item and request types, state codes and sizes for the clustering
// feature accumulator.
// ----------------------------------------------------------------------------
package cfa_pkg;

   localparam int DIMENSIONS  = 8;
   localparam int LANES       = 8;
   localparam int ACTIVE_DIMS = (DIMENSIONS < LANES) ? DIMENSIONS : LANES;
   localparam int DIV_W       = 98;
   localparam int CEN_BITS    = 48;
   localparam logic [6:0] STEPS_METRIC = 7'(DIV_W);
   localparam logic [6:0] STEPS_CEN    = 7'(CEN_BITS);
   localparam logic [5:0] SQRT_STEPS   = 6'd32;

   localparam logic [1:0] REQ_MERGE  = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   typedef enum logic [1:0] {OP_MERGE, OP_REMOVE, OP_CLEAR} op_type;

   typedef struct packed {
      op_type             op;
      logic               in_range;
      logic [15:0]        count;
      logic [62:0]        sq;
      logic signed [31:0] comp;
      logic [2:0]         idx;
      logic               last;
   } item_type;

   typedef enum logic [1:0] {MO_NN, MO_NSLO, MO_NSHI, MO_SQ} mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_ACC,
      ST_DIVR_GO, ST_DIVR_WT, ST_SQR_GO, ST_SQR_WT,
      ST_DIVD_GO, ST_DIVD_WT, ST_SQD_GO, ST_SQD_WT,
      ST_CEN_GO, ST_CEN_WT, ST_OUT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [63:0]       divisor;
      logic [6:0]        steps;
   } div_req_type;

endpackage

@@ sv/cfa_front.sv @@
// ----------------------------------------------------------------------------
// cfa_front: input classification and item queue
// Decodes the request type, checks the dimension index and queues items
// for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module cfa_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_type,
   input  logic [15:0]        req_entry_count,
   input  logic [62:0]        req_entry_square_sum,
   input  logic signed [31:0] req_sum_component,
   input  logic [2:0]         req_component_index,
   input  logic               req_last_component,
   input  logic               deq,
   output logic               item_valid,
   output cfa_pkg::item_type  item
);

   cfa_pkg::item_type mem_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   cfa_pkg::item_type cls;
   logic              keep;
   logic              wr;
   logic              rd;

   always_comb begin
      cls.in_range = (32'(req_component_index) < cfa_pkg::ACTIVE_DIMS);
      cls.count    = req_entry_count;
      cls.sq       = req_entry_square_sum;
      cls.comp     = req_sum_component;
      cls.idx      = req_component_index;
      cls.last     = req_last_component;
      keep         = 1'b1;
      cls.op       = cfa_pkg::OP_MERGE;
      unique case (req_type)
         cfa_pkg::REQ_MERGE:  cls.op = cfa_pkg::OP_MERGE;
         cfa_pkg::REQ_REMOVE: cls.op = cfa_pkg::OP_REMOVE;
         cfa_pkg::REQ_CLEAR:  cls.op = cfa_pkg::OP_CLEAR;
         default:             keep   = 1'b0;   // drop unknown requests
      endcase
   end

   assign full       = (cnt_ff == 2'd2);
   assign wr         = push & ~full & keep;
   assign item_valid = (cnt_ff != 2'd0);
   assign rd         = deq & item_valid;
   assign item       = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = wr ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = rd ? ~rd_ptr_ff : rd_ptr_ff;
   assign cnt_in    = cnt_ff + 2'(wr) - 2'(rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

@@ sv/cfa_div.sv @@
// ----------------------------------------------------------------------------
// cfa_div: restoring divider
// Unsigned division, one quotient bit per cycle, dividend taken MSB first.
// ----------------------------------------------------------------------------
module cfa_div (
   input  logic                           clock,
   input  logic                           reset,
   input  cfa_pkg::div_req_type           req,
   output logic                           busy,
   output logic [cfa_pkg::DIV_W-1:0]      quotient
);

   logic                      busy_ff;
   logic [6:0]                cnt_ff;
   logic [cfa_pkg::DIV_W-1:0] n_ff;
   logic [cfa_pkg::DIV_W-1:0] q_ff;
   logic [63:0]               r_ff;
   logic [63:0]               d_ff;
   logic [64:0]               r_sh;
   logic                      ge;
   logic [64:0]               r_dif;

   assign r_sh  = {r_ff, n_ff[cfa_pkg::DIV_W-1]};
   assign ge    = (r_sh >= {1'b0, d_ff});
   assign r_dif = r_sh - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == 7'd1) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         n_ff   <= req.dividend;
         d_ff   <= req.divisor;
         r_ff   <= '0;
         q_ff   <= '0;
         cnt_ff <= req.steps;
      end else if (busy_ff) begin
         n_ff   <= n_ff << 1;
         r_ff   <= ge ? r_dif[63:0] : r_sh[63:0];
         q_ff   <= {q_ff[cfa_pkg::DIV_W-2:0], ge};
         cnt_ff <= cnt_ff - 7'd1;
      end
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule

@@ sv/cfa_sqrt.sv @@
// ----------------------------------------------------------------------------
// cfa_sqrt: integer square root
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cfa_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] x,
   output logic        busy,
   output logic [31:0] root
);

   logic        busy_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] x_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [63:0] trial;
   logic        take;

   assign trial = res_ff + bit_ff;
   assign take  = (x_ff >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == 6'd1) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= x;
         res_ff <= '0;
         bit_ff <= 64'd1 << 62;
         cnt_ff <= cfa_pkg::SQRT_STEPS;
      end else if (busy_ff) begin
         x_ff   <= take ? x_ff - trial : x_ff;
         res_ff <= take ? (res_ff >> 1) + bit_ff : res_ff >> 1;
         bit_ff <= bit_ff >> 2;
         cnt_ff <= cnt_ff - 6'd1;
      end
   end

   assign busy = busy_ff;
   assign root = res_ff[31:0];

endmodule

@@ sv/cfa_back.sv @@
// ----------------------------------------------------------------------------
// cfa_back: feature update and metric sequencer
// Applies queued items to the feature, then computes radius, diameter and
// centroids with a shared multiplier, divider and root unit.
// ----------------------------------------------------------------------------
module cfa_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  cfa_pkg::item_type         item,
   output logic                      deq,
   input  logic                      pop,
   output logic                      empty,
   output logic signed [31:0]        rsp_centroid_component,
   output logic [2:0]                rsp_out_index,
   output logic [31:0]               rsp_radius,
   output logic [31:0]               rsp_diameter,
   output logic [31:0]               rsp_total_count,
   output logic                      rsp_last_result
);

   localparam logic [47:0] LS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] LS_MIN = 48'h8000_0000_0000;
   localparam logic [2:0]  K_LAST = 3'(cfa_pkg::ACTIVE_DIMS - 1);

   cfa_pkg::state_type   state_ff, state_in;
   logic [31:0]          cnt_ff;
   logic [63:0]          sq_ff;
   logic signed [47:0]   ls_ff [cfa_pkg::LANES];
   cfa_pkg::mul_op_type  op_ff;
   logic [1:0]           j_ff;
   logic [2:0]           k_ff;
   logic [63:0]          prod_ff;
   logic [63:0]          nn_ff;
   logic signed [99:0]   acc_ff;
   logic [95:0]          t_ff;
   logic [31:0]          rad_ff;
   logic [31:0]          diam_ff;
   logic [31:0]          cen_ff;
   logic                 oval_ff;
   logic signed [31:0]   o_cen_ff;
   logic [2:0]           o_idx_ff;
   logic [31:0]          o_rad_ff;
   logic [31:0]          o_diam_ff;
   logic [31:0]          o_cnt_ff;
   logic                 o_last_ff;

   logic [2:0]           addr;
   logic signed [47:0]   ls_rd;
   logic [47:0]          mag;
   logic signed [48:0]   ls_sum;
   logic [47:0]          ls_new;
   logic [32:0]          cnt_add;
   logic [31:0]          cnt_next;
   logic [64:0]          sq_add;
   logic [63:0]          sq_next;
   logic [31:0]          mul_a, mul_b;
   logic [99:0]          term;
   logic                 op_sub;
   logic                 mul_done;
   logic                 out_free;
   logic                 out_load;
   logic                 sq_start;
   logic [63:0]          sq_x;
   logic                 sq_busy;
   logic [31:0]          root;
   logic                 div_busy;
   logic [cfa_pkg::DIV_W-1:0] quo;
   logic                 quo_sat;
   logic [31:0]          cen_val;
   cfa_pkg::div_req_type div_req;

   // Read port of the linear sums: item index on update, lane counter after.
   assign addr  = (state_ff == cfa_pkg::ST_IDLE) ? item.idx : k_ff;
   assign ls_rd = ls_ff[addr];
   assign mag   = ls_rd[47] ? 48'(-ls_rd) : 48'(ls_rd);

   always_comb begin
      ls_sum = (item.op == cfa_pkg::OP_MERGE) ?
               {ls_rd[47], ls_rd} + 49'(item.comp) :
               {ls_rd[47], ls_rd} - 49'(item.comp);
      if (ls_sum[48] != ls_sum[47]) begin
         ls_new = ls_sum[48] ? LS_MIN : LS_MAX;
      end else begin
         ls_new = ls_sum[47:0];
      end
      cnt_add = {1'b0, cnt_ff} + 33'(item.count);
      sq_add  = {1'b0, sq_ff} + 65'(item.sq);
      priority if (item.op == cfa_pkg::OP_CLEAR) begin
         cnt_next = '0;
         sq_next  = '0;
      end else if (!item.last) begin
         cnt_next = cnt_ff;
         sq_next  = sq_ff;
      end else if (item.op == cfa_pkg::OP_MERGE) begin
         cnt_next = cnt_add[32] ? '1 : cnt_add[31:0];
         sq_next  = sq_add[64] ? '1 : sq_add[63:0];
      end else begin
         cnt_next = (cnt_ff > 32'(item.count)) ? cnt_ff - 32'(item.count) : '0;
         sq_next  = (sq_ff > 64'(item.sq)) ? sq_ff - 64'(item.sq) : '0;
      end
   end

   // Shared multiplier operands and accumulate shift.
   always_comb begin
      mul_a  = cnt_ff;
      mul_b  = cnt_ff;
      term   = 100'(prod_ff);
      op_sub = 1'b0;
      unique case (op_ff)
         cfa_pkg::MO_NN: begin
            mul_b = cnt_ff;
         end
         cfa_pkg::MO_NSLO: begin
            mul_b = sq_ff[31:0];
         end
         cfa_pkg::MO_NSHI: begin
            mul_b = sq_ff[63:32];
            term  = 100'(prod_ff) << 32;
         end
         cfa_pkg::MO_SQ: begin
            op_sub = 1'b1;
            unique case (j_ff)
               2'd0: begin
                  mul_a = mag[31:0];
                  mul_b = mag[31:0];
               end
               2'd1: begin
                  mul_a = mag[31:0];
                  mul_b = {16'd0, mag[47:32]};
                  term  = 100'(prod_ff) << 33;
               end
               default: begin
                  mul_a = {16'd0, mag[47:32]};
                  mul_b = {16'd0, mag[47:32]};
                  term  = 100'(prod_ff) << 64;
               end
            endcase
         end
         default: begin
            mul_b = cnt_ff;
         end
      endcase
   end

   assign mul_done = (op_ff == cfa_pkg::MO_SQ) && (j_ff == 2'd2) && (k_ff == K_LAST);
   assign out_free = ~oval_ff | pop;
   assign quo_sat  = |quo[cfa_pkg::DIV_W-1:64];
   assign sq_x     = quo[63:0];

   always_comb begin
      if (!ls_rd[47]) begin
         cen_val = (quo[47:0] > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
      end else begin
         cen_val = (quo[47:0] > 48'h8000_0000) ? 32'h8000_0000 : 32'(-quo[31:0]);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfa_pkg::ST_IDLE: begin
            if (item_valid && item.last) begin
               state_in = (cnt_next > 32'd1) ? cfa_pkg::ST_MUL : cfa_pkg::ST_CEN_GO;
            end
         end
         cfa_pkg::ST_MUL:  state_in = cfa_pkg::ST_ACC;
         cfa_pkg::ST_ACC:  state_in = mul_done ? cfa_pkg::ST_DIVR_GO : cfa_pkg::ST_MUL;
         cfa_pkg::ST_DIVR_GO: state_in = cfa_pkg::ST_DIVR_WT;
         cfa_pkg::ST_DIVR_WT: begin
            if (!div_busy) begin
               state_in = quo_sat ? cfa_pkg::ST_DIVD_GO : cfa_pkg::ST_SQR_GO;
            end
         end
         cfa_pkg::ST_SQR_GO:  state_in = cfa_pkg::ST_SQR_WT;
         cfa_pkg::ST_SQR_WT:  if (!sq_busy) state_in = cfa_pkg::ST_DIVD_GO;
         cfa_pkg::ST_DIVD_GO: state_in = cfa_pkg::ST_DIVD_WT;
         cfa_pkg::ST_DIVD_WT: begin
            if (!div_busy) begin
               state_in = quo_sat ? cfa_pkg::ST_CEN_GO : cfa_pkg::ST_SQD_GO;
            end
         end
         cfa_pkg::ST_SQD_GO:  state_in = cfa_pkg::ST_SQD_WT;
         cfa_pkg::ST_SQD_WT:  if (!sq_busy) state_in = cfa_pkg::ST_CEN_GO;
         cfa_pkg::ST_CEN_GO:  state_in = (cnt_ff == '0) ? cfa_pkg::ST_OUT : cfa_pkg::ST_CEN_WT;
         cfa_pkg::ST_CEN_WT:  if (!div_busy) state_in = cfa_pkg::ST_OUT;
         cfa_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = (k_ff == K_LAST) ? cfa_pkg::ST_IDLE : cfa_pkg::ST_CEN_GO;
            end
         end
         default: state_in = cfa_pkg::ST_IDLE;
      endcase
   end

   // Strobes toward the queue, the shared units and the output register.
   always_comb begin
      deq              = 1'b0;
      sq_start         = 1'b0;
      out_load         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = {2'b0, t_ff};
      div_req.divisor  = nn_ff;
      div_req.steps    = cfa_pkg::STEPS_METRIC;
      unique case (state_ff)
         cfa_pkg::ST_IDLE:    deq = item_valid;
         cfa_pkg::ST_DIVR_GO: div_req.start = 1'b1;
         cfa_pkg::ST_DIVD_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, t_ff, 1'b0};
            div_req.divisor  = nn_ff - 64'(cnt_ff);
         end
         cfa_pkg::ST_SQR_GO, cfa_pkg::ST_SQD_GO: sq_start = 1'b1;
         cfa_pkg::ST_CEN_GO: begin
            div_req.start    = (cnt_ff != '0);
            div_req.dividend = {mag, 50'd0};
            div_req.divisor  = 64'(cnt_ff);
            div_req.steps    = cfa_pkg::STEPS_CEN;
         end
         cfa_pkg::ST_OUT:     out_load = out_free;
         default: begin
            deq = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfa_pkg::ST_IDLE;
         cnt_ff   <= '0;
         sq_ff    <= '0;
         oval_ff  <= 1'b0;
         for (int i = 0; i < cfa_pkg::LANES; i++) begin
            ls_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         oval_ff  <= out_load | (oval_ff & ~pop);
         if (deq) begin
            cnt_ff <= cnt_next;
            sq_ff  <= sq_next;
            if (item.op == cfa_pkg::OP_CLEAR) begin
               for (int i = 0; i < cfa_pkg::LANES; i++) begin
                  ls_ff[i] <= '0;
               end
            end else if (item.in_range) begin
               ls_ff[item.idx] <= ls_new;
            end
         end
      end
   end

   // Metric datapath.
   always_ff @(posedge clock) begin
      priority case (state_ff)
         cfa_pkg::ST_IDLE: begin
            op_ff   <= cfa_pkg::MO_NN;
            j_ff    <= '0;
            k_ff    <= '0;
            acc_ff  <= '0;
            rad_ff  <= '0;
            diam_ff <= '0;
         end
         cfa_pkg::ST_MUL: prod_ff <= mul_a * mul_b;
         cfa_pkg::ST_ACC: begin
            if (op_ff == cfa_pkg::MO_NN) begin
               nn_ff <= prod_ff;
            end else begin
               acc_ff <= op_sub ? acc_ff - $signed(term) : acc_ff + $signed(term);
            end
            unique case (op_ff)
               cfa_pkg::MO_NN:   op_ff <= cfa_pkg::MO_NSLO;
               cfa_pkg::MO_NSLO: op_ff <= cfa_pkg::MO_NSHI;
               cfa_pkg::MO_NSHI: op_ff <= cfa_pkg::MO_SQ;
               default: begin
                  if (j_ff == 2'd2) begin
                     j_ff <= '0;
                     k_ff <= mul_done ? 3'd0 : k_ff + 3'd1;
                  end else begin
                     j_ff <= j_ff + 2'd1;
                  end
               end
            endcase
            // clamp a negative radicand
            t_ff <= (acc_ff[99] | (op_sub & (acc_ff < $signed(term)))) ? '0 :
                    96'(acc_ff - (op_sub ? $signed(term) : -$signed(term)));
         end
         cfa_pkg::ST_DIVR_WT: if (!div_busy && quo_sat) rad_ff <= '1;
         cfa_pkg::ST_SQR_WT:  if (!sq_busy) rad_ff <= root;
         cfa_pkg::ST_DIVD_WT: if (!div_busy && quo_sat) diam_ff <= '1;
         cfa_pkg::ST_SQD_WT:  if (!sq_busy) diam_ff <= root;
         cfa_pkg::ST_CEN_GO:  cen_ff <= '0;
         cfa_pkg::ST_CEN_WT:  if (!div_busy) cen_ff <= cen_val;
         cfa_pkg::ST_OUT:     if (out_free) k_ff <= k_ff + 3'd1;
         default: begin
            cen_ff <= cen_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         o_cen_ff  <= cen_ff;
         o_idx_ff  <= k_ff;
         o_rad_ff  <= rad_ff;
         o_diam_ff <= diam_ff;
         o_cnt_ff  <= cnt_ff;
         o_last_ff <= (k_ff == K_LAST);
      end
   end

   cfa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .busy     (div_busy),
      .quotient (quo)
   );

   cfa_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .x     (sq_x),
      .busy  (sq_busy),
      .root  (root)
   );

   assign empty                  = ~oval_ff;
   assign rsp_centroid_component = o_cen_ff;
   assign rsp_out_index          = o_idx_ff;
   assign rsp_radius             = o_rad_ff;
   assign rsp_diameter           = o_diam_ff;
   assign rsp_total_count        = o_cnt_ff;
   assign rsp_last_result        = o_last_ff;

endmodule

@@ sv/clustering_feature_accumulator.sv @@
// ----------------------------------------------------------------------------
// clustering_feature_accumulator: clustering feature update
// Keeps a point count, per-dimension linear sums and a square sum; merges,
// removes or clears entries and reports centroid, radius and diameter.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload
//  --------  ---------------  ---------------------------------------------
//  request   push / full      req_type, entry count, square sum, component
//  response  empty / pop      centroid, index, radius, diameter, count, last
//
//  A merge or remove item that is not last updates the linear sum of its
//  index, if in range. A last item starts a run: with a count above one,
//  shared 32x32 multiplies, two divides and up to two roots, then one
//  divide per active dimension for the centroids, skipped at count zero.
//  Reset clears the count, sums and queues directly; no clearing pass.
//  A two-entry queue keeps taking words while a run is busy; a stalled
//  response holds in the output register and pauses the run.
//
module clustering_feature_accumulator (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_type,
   input  logic [15:0]        req_entry_count,
   input  logic [62:0]        req_entry_square_sum,
   input  logic signed [31:0] req_sum_component,
   input  logic [2:0]         req_component_index,
   input  logic               req_last_component,
   output logic               empty,
   input  logic               pop,
   output logic signed [31:0] rsp_centroid_component,
   output logic [2:0]         rsp_out_index,
   output logic [31:0]        rsp_radius,
   output logic [31:0]        rsp_diameter,
   output logic [31:0]        rsp_total_count,
   output logic               rsp_last_result
);

   logic              item_valid;
   cfa_pkg::item_type item;
   logic              deq;

   // Front end: decode and queue words.
   cfa_front u_front (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_type             (req_type),
      .req_entry_count      (req_entry_count),
      .req_entry_square_sum (req_entry_square_sum),
      .req_sum_component    (req_sum_component),
      .req_component_index  (req_component_index),
      .req_last_component   (req_last_component),
      .deq                  (deq),
      .item_valid           (item_valid),
      .item                 (item)
   );

   // Back end: update feature, compute metrics, emit responses.
   cfa_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .item_valid             (item_valid),
      .item                   (item),
      .deq                    (deq),
      .pop                    (pop),
      .empty                  (empty),
      .rsp_centroid_component (rsp_centroid_component),
      .rsp_out_index          (rsp_out_index),
      .rsp_radius             (rsp_radius),
      .rsp_diameter           (rsp_diameter),
      .rsp_total_count        (rsp_total_count),
      .rsp_last_result        (rsp_last_result)
   );

`ifndef SYNTHESIS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (32'(rsp_out_index) < cfa_pkg::ACTIVE_DIMS))
      else $error("response index beyond active dimensions");

   a_small_count: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_total_count <= 32'd1) |-> (rsp_radius == '0 && rsp_diameter == '0))
      else $error("metrics nonzero for small count");

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last_result) |-> (32'(rsp_out_index) == cfa_pkg::ACTIVE_DIMS - 1))
      else $error("last response on wrong index");

   a_empty_cen: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_total_count == '0) |-> (rsp_centroid_component == '0))
      else $error("centroid nonzero for empty feature");
`endif

endmodule
